// ===== src/pngpal_pkg.sv =====
// Shared types, constants and a helper function for the PNG palette extractor.
`timescale 1ns / 1ps

package pngpal_pkg;

  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_LEN  = 3'd1,
    PH_TYPE = 3'd2,
    PH_SKIP = 3'd3,
    PH_CRC  = 3'd4,
    PH_PAL  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_ENTRY = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_NONE  = 2'd2,
    KIND_TRUNC = 2'd3
  } kind_t;

  localparam int FILE_SIZE_W = 29;
  localparam int MAX_ENTRIES = 256;
  localparam int SIG_BYTES = 8;
  localparam int HDR_BYTES = 12;
  localparam logic [31:0] TYPE_PLTE = 32'h504C_5445;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;
  localparam logic [31:0] PAL_LEN_LIMIT = 32'(3 * MAX_ENTRIES);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

  // One request from the parser to the output stage. When pair is set the
  // request expands into an entry followed by a completion carrying count.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  idx;
    logic [23:0] color;
    logic [8:0]  count;
    logic        pair;
  } cmd_t;

  // Floor of x / 3 for x below 768, by multiplication with a reciprocal.
  function automatic logic [8:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'd683;
    return p[19:11];
  endfunction

endpackage

// ===== src/pngpal_parser.sv =====
// Front end: accepts file bytes, walks the chunk structure and issues requests.
`timescale 1ns / 1ps

module pngpal_parser (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pngpal_pkg::FILE_SIZE_W-1:0]  cfg_wdata,
  input  logic                                accept,
  input  logic [7:0]                          data_byte,
  input  logic                                first_byte,
  output logic                                cmd_valid,
  output pngpal_pkg::cmd_t                    cmd
);

  localparam int FW = pngpal_pkg::FILE_SIZE_W;
  localparam int SW = FW + 5;

  logic [FW-1:0]      file_size_r;
  pngpal_pkg::phase_t phase_r, phase_nxt, cur_phase;
  logic [FW-1:0]      off_r, off_nxt, cur_off;
  logic [31:0]        fc_r, fc_nxt, cur_fc, fc_inc;
  logic [31:0]        len_r, len_nxt, cur_len, len_new;
  logic [31:0]        type_r, type_nxt, cur_type, type_new;
  logic [15:0]        acc_r, acc_nxt, cur_acc;
  logic [8:0]         target_r, target_nxt, cur_target, n_entries;
  logic [8:0]         done_r, done_nxt, cur_done, done_inc;
  logic               fin_r, fin_nxt, cur_fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_size_r <= '0;
    end else if (cfg_we) begin
      file_size_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= pngpal_pkg::PH_SIG;
      off_r    <= '0;
      fc_r     <= '0;
      len_r    <= '0;
      type_r   <= '0;
      acc_r    <= '0;
      target_r <= '0;
      done_r   <= '0;
      fin_r    <= 1'b1;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      off_r    <= off_nxt;
      fc_r     <= fc_nxt;
      len_r    <= len_nxt;
      type_r   <= type_nxt;
      acc_r    <= acc_nxt;
      target_r <= target_nxt;
      done_r   <= done_nxt;
      fin_r    <= fin_nxt;
    end
  end

  always_comb begin
    // A first byte restarts the walk before the byte itself is handled.
    cur_phase  = first_byte ? pngpal_pkg::PH_SIG : phase_r;
    cur_off    = first_byte ? '0 : off_r;
    cur_fc     = first_byte ? '0 : fc_r;
    cur_len    = first_byte ? '0 : len_r;
    cur_type   = first_byte ? '0 : type_r;
    cur_acc    = first_byte ? '0 : acc_r;
    cur_target = first_byte ? '0 : target_r;
    cur_done   = first_byte ? '0 : done_r;
    cur_fin    = first_byte ? 1'b0 : fin_r;

    fc_inc   = cur_fc + 32'd1;
    len_new  = {cur_len[23:0], data_byte};
    type_new = {cur_type[23:0], data_byte};
    done_inc = cur_done + 9'd1;
    n_entries = (cur_len >= pngpal_pkg::PAL_LEN_LIMIT) ? 9'(pngpal_pkg::MAX_ENTRIES)
                                                       : pngpal_pkg::div3(cur_len[9:0]);

    phase_nxt  = cur_phase;
    off_nxt    = cur_off;
    fc_nxt     = cur_fc;
    len_nxt    = cur_len;
    type_nxt   = cur_type;
    acc_nxt    = cur_acc;
    target_nxt = cur_target;
    done_nxt   = cur_done;
    fin_nxt    = cur_fin;

    cmd_valid  = 1'b0;
    cmd.kind   = pngpal_pkg::KIND_NONE;
    cmd.idx    = '0;
    cmd.color  = '0;
    cmd.count  = '0;
    cmd.pair   = 1'b0;

    if (first_byte &&
        (SW'(file_size_r) < SW'(pngpal_pkg::SIG_BYTES + pngpal_pkg::HDR_BYTES))) begin
      fin_nxt   = 1'b1;
      cmd_valid = 1'b1;
      cmd.kind  = pngpal_pkg::KIND_NONE;
    end else if (!cur_fin) begin
      off_nxt = cur_off + FW'(1);
      case (cur_phase)
        pngpal_pkg::PH_SIG: begin
          fc_nxt = fc_inc;
          if (fc_inc >= 32'(pngpal_pkg::SIG_BYTES)) begin
            phase_nxt = pngpal_pkg::PH_LEN;
            fc_nxt    = '0;
            len_nxt   = '0;
          end
        end
        pngpal_pkg::PH_LEN: begin
          len_nxt = len_new;
          fc_nxt  = fc_inc;
          if (fc_inc >= 32'd4) begin
            if ((SW'(cur_off) + SW'(9) + SW'(len_new)) > SW'(file_size_r)) begin
              fin_nxt   = 1'b1;
              cmd_valid = 1'b1;
              cmd.kind  = pngpal_pkg::KIND_TRUNC;
            end else begin
              phase_nxt = pngpal_pkg::PH_TYPE;
              fc_nxt    = '0;
              type_nxt  = '0;
            end
          end
        end
        pngpal_pkg::PH_TYPE: begin
          type_nxt = type_new;
          fc_nxt   = fc_inc;
          if (fc_inc >= 32'd4) begin
            fc_nxt = '0;
            if (type_new == pngpal_pkg::TYPE_PLTE) begin
              target_nxt = n_entries;
              done_nxt   = '0;
              acc_nxt    = '0;
              if (n_entries == 9'd0) begin
                fin_nxt   = 1'b1;
                cmd_valid = 1'b1;
                cmd.kind  = pngpal_pkg::KIND_DONE;
              end else begin
                phase_nxt = pngpal_pkg::PH_PAL;
              end
            end else if (type_new == pngpal_pkg::TYPE_IEND) begin
              fin_nxt   = 1'b1;
              cmd_valid = 1'b1;
              cmd.kind  = pngpal_pkg::KIND_NONE;
            end else begin
              phase_nxt = (cur_len == 32'd0) ? pngpal_pkg::PH_CRC : pngpal_pkg::PH_SKIP;
            end
          end
        end
        pngpal_pkg::PH_SKIP: begin
          fc_nxt = fc_inc;
          if (fc_inc >= cur_len) begin
            phase_nxt = pngpal_pkg::PH_CRC;
            fc_nxt    = '0;
          end
        end
        pngpal_pkg::PH_CRC: begin
          fc_nxt = fc_inc;
          if (fc_inc >= 32'd4) begin
            if ((SW'(cur_off) + SW'(1 + pngpal_pkg::HDR_BYTES)) > SW'(file_size_r)) begin
              fin_nxt   = 1'b1;
              cmd_valid = 1'b1;
              cmd.kind  = pngpal_pkg::KIND_NONE;
            end else begin
              phase_nxt = pngpal_pkg::PH_LEN;
              fc_nxt    = '0;
              len_nxt   = '0;
              type_nxt  = '0;
            end
          end
        end
        pngpal_pkg::PH_PAL: begin
          if (cur_fc < 32'd2) begin
            acc_nxt = {cur_acc[7:0], data_byte};
            fc_nxt  = fc_inc;
          end else begin
            fc_nxt    = '0;
            acc_nxt   = '0;
            done_nxt  = done_inc;
            cmd_valid = 1'b1;
            cmd.kind  = pngpal_pkg::KIND_ENTRY;
            cmd.idx   = cur_done[7:0];
            cmd.color = {cur_acc, data_byte};
            if (done_inc >= cur_target) begin
              fin_nxt   = 1'b1;
              cmd.count = done_inc;
              cmd.pair  = 1'b1;
            end
          end
        end
        default: begin
          fin_nxt = 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== src/pngpal_fifo.sv =====
// Short request queue between the parser and the output stage.
`timescale 1ns / 1ps

module pngpal_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pngpal_pkg::cmd_t  push_cmd,
  input  logic              pop,
  output logic              head_valid,
  output pngpal_pkg::cmd_t  head_cmd,
  output logic              full
);

  localparam int AW = pngpal_pkg::FIFO_AW;
  localparam int CW = pngpal_pkg::FIFO_CW;

  pngpal_pkg::cmd_t slot_r [pngpal_pkg::FIFO_DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];
  assign full       = (count_r == CW'(pngpal_pkg::FIFO_DEPTH));

endmodule

// ===== src/pngpal_emitter.sv =====
// Back end: expands queued requests into results and holds them in the output register.
`timescale 1ns / 1ps

module pngpal_emitter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  pngpal_pkg::cmd_t  head_cmd,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [47:0]       out_tdata,
  output logic [1:0]        out_tuser,
  output logic              out_tlast
);

  logic               valid_r;
  pngpal_pkg::kind_t  kind_r;
  logic [7:0]         idx_r;
  logic [23:0]        color_r;
  logic [8:0]         count_r;
  logic               last_r;
  logic               pend_r;
  logic [8:0]         pend_count_r;
  logic               load;

  assign load = !valid_r || out_tready;
  assign pop  = load && !pend_r && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else if (load) begin
      if (pend_r) begin
        valid_r <= 1'b1;
        pend_r  <= 1'b0;
      end else begin
        valid_r <= head_valid;
        pend_r  <= head_valid && head_cmd.pair;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_r) begin
        kind_r  <= pngpal_pkg::KIND_DONE;
        idx_r   <= '0;
        color_r <= '0;
        count_r <= pend_count_r;
        last_r  <= 1'b1;
      end else begin
        kind_r       <= head_cmd.kind;
        idx_r        <= head_cmd.idx;
        color_r      <= head_cmd.color;
        count_r      <= head_cmd.pair ? 9'd0 : head_cmd.count;
        last_r       <= !head_cmd.pair;
        pend_count_r <= head_cmd.count;
      end
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {7'd0, count_r, color_r, idx_r};
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

endmodule

// ===== src/png_palette_chunk_extractor.sv =====
// Top level of the PNG palette extractor: parser, request queue and output stage.
`timescale 1ns / 1ps

// The block takes a PNG file one byte per request on the in_ channel; a request
// with in_tuser set marks the first byte of a file and restarts the parse.
// Before a file is streamed, its total length is written through cfg_we and
// cfg_wdata. Results leave on the out_ channel: out_tuser gives the kind
// (palette entry, palette complete, no palette, truncated chunk), out_tdata
// the entry index, color and count, and out_tlast marks the final result
// caused by one byte. Bytes are taken at one per cycle while in_tready is
// high. A result is registered in the queue and then in the output register;
// the byte that completes the last palette entry causes two results, the
// entry and then the completion. The parser and the output stage are parted
// by a four-request queue, so input continues while the receiver stalls,
// until the queue fills and in_tready drops. After reset the block ignores
// bytes until a first byte arrives, and the file length register reads zero.
module png_palette_chunk_extractor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [28:0] cfg_wdata,   // file_size
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tuser,    // [0] first_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // [7:0] entry_index, [31:8] entry_color, [40:32] entry_count
  output logic [1:0]  out_tuser,   // [1:0] result_kind
  output logic        out_tlast
);

  logic             accept;
  logic             cmd_valid;
  pngpal_pkg::cmd_t cmd;
  logic             fifo_full;
  logic             head_valid;
  pngpal_pkg::cmd_t head_cmd;
  logic             pop;

  assign in_tready = !fifo_full;
  assign accept    = in_tvalid && in_tready;

  pngpal_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .accept     (accept),
    .data_byte  (in_tdata),
    .first_byte (in_tuser),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd)
  );

  pngpal_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept && cmd_valid),
    .push_cmd   (cmd),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .full       (fifo_full)
  );

  pngpal_emitter u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tuser == pngpal_pkg::KIND_ENTRY && !out_tlast) |=>
    (out_tvalid && out_tuser == pngpal_pkg::KIND_DONE && out_tlast))
    else $error("palette completion did not follow the last entry");

  a_final_kinds_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != pngpal_pkg::KIND_ENTRY) |-> out_tlast)
    else $error("final result kind without last flag");

  a_backlog_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled while output stage is empty");
`endif

endmodule

// ===== tb/sv/png_palette_chunk_extractor_test.sv =====
// Self-checking testbench for the PNG palette chunk extractor: byte stream in, palette results out.
`timescale 1ns / 1ps

module png_palette_chunk_extractor_test;

  localparam logic [31:0] PLTE_TAG = 32'h504C_5445;
  localparam logic [31:0] IEND_TAG = 32'h4945_4E44;
  localparam logic [31:0] IHDR_TAG = 32'h4948_4452;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BYTES = 700;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } byte_item_t;

  typedef struct packed {
    pngpal_pkg::kind_t kind;
    logic [7:0]        idx;
    logic [23:0]       color;
    logic [8:0]        count;
    logic              last;
  } palette_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [28:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  png_palette_chunk_extractor i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  byte_item_t      file_bytes_q[$];
  byte_item_t      build_q[$];
  palette_result_t palette_results_q[$];

  // Copy of the parser state.
  logic [28:0]        size_reg = '0;
  pngpal_pkg::phase_t phase = pngpal_pkg::PH_SIG;
  logic [28:0]        offset = '0;
  logic [31:0]        field_cnt = '0;
  logic [31:0]        chunk_len = '0;
  logic [31:0]        chunk_tag = '0;
  logic [15:0]        rgb_acc = '0;
  logic [8:0]         entry_target = '0;
  logic [8:0]         entry_cnt = '0;
  logic               halted = 1'b1;

  int         errors = 0;
  int         cycles = 0;
  int         in_gap = 0;
  int         out_gap = 0;
  bit         in_calm = 1'b0;
  bit         out_calm = 1'b0;
  bit         in_fired = 1'b0;
  bit         out_fired = 1'b0;
  byte_item_t cur;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = ~calm;
    return calm ? 0 : int'($urandom_range(0, 12));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  task automatic note_result(input pngpal_pkg::kind_t k, input logic [7:0] ix,
                             input logic [23:0] rgb, input logic [8:0] cnt,
                             input logic lst);
    palette_results_q.push_back('{k, ix, rgb, cnt, lst});
  endtask

  task automatic end_walk(input pngpal_pkg::kind_t k);
    halted = 1'b1;
    note_result(k, 8'd0, 24'd0, 9'd0, 1'b1);
  endtask

  task automatic walk_png_byte(input logic [7:0] b, input logic first);
    logic [28:0] here;
    logic [31:0] n;
    logic [7:0]  ix;
    if (first) begin
      phase = pngpal_pkg::PH_SIG;
      offset = '0;
      field_cnt = '0;
      chunk_len = '0;
      chunk_tag = '0;
      rgb_acc = '0;
      entry_target = '0;
      entry_cnt = '0;
      halted = 1'b0;
      if (size_reg < 29'(pngpal_pkg::SIG_BYTES + pngpal_pkg::HDR_BYTES)) begin
        end_walk(pngpal_pkg::KIND_NONE);
        return;
      end
    end
    if (halted) return;
    here = offset;
    offset = here + 29'd1;
    case (phase)
      pngpal_pkg::PH_SIG: begin
        field_cnt++;
        if (field_cnt >= 32'd8) begin
          phase = pngpal_pkg::PH_LEN;
          field_cnt = '0;
          chunk_len = '0;
        end
      end
      pngpal_pkg::PH_LEN: begin
        chunk_len = {chunk_len[23:0], b};
        field_cnt++;
        if (field_cnt >= 32'd4) begin
          if (64'(here) + 64'd9 + 64'(chunk_len) > 64'(size_reg)) begin
            end_walk(pngpal_pkg::KIND_TRUNC);
          end else begin
            phase = pngpal_pkg::PH_TYPE;
            field_cnt = '0;
            chunk_tag = '0;
          end
        end
      end
      pngpal_pkg::PH_TYPE: begin
        chunk_tag = {chunk_tag[23:0], b};
        field_cnt++;
        if (field_cnt >= 32'd4) begin
          field_cnt = '0;
          if (chunk_tag == PLTE_TAG) begin
            n = chunk_len / 32'd3;
            if (n > 32'(pngpal_pkg::MAX_ENTRIES)) n = 32'(pngpal_pkg::MAX_ENTRIES);
            entry_target = n[8:0];
            entry_cnt = '0;
            rgb_acc = '0;
            if (n == 32'd0) begin
              halted = 1'b1;
              note_result(pngpal_pkg::KIND_DONE, 8'd0, 24'd0, 9'd0, 1'b1);
            end else begin
              phase = pngpal_pkg::PH_PAL;
            end
          end else if (chunk_tag == IEND_TAG) begin
            end_walk(pngpal_pkg::KIND_NONE);
          end else begin
            phase = (chunk_len == 32'd0) ? pngpal_pkg::PH_CRC : pngpal_pkg::PH_SKIP;
          end
        end
      end
      pngpal_pkg::PH_SKIP: begin
        field_cnt++;
        if (field_cnt >= chunk_len) begin
          phase = pngpal_pkg::PH_CRC;
          field_cnt = '0;
        end
      end
      pngpal_pkg::PH_CRC: begin
        field_cnt++;
        if (field_cnt >= 32'd4) begin
          if (64'(here) + 64'd13 > 64'(size_reg)) begin
            end_walk(pngpal_pkg::KIND_NONE);
          end else begin
            phase = pngpal_pkg::PH_LEN;
            field_cnt = '0;
            chunk_len = '0;
            chunk_tag = '0;
          end
        end
      end
      pngpal_pkg::PH_PAL: begin
        if (field_cnt < 32'd2) begin
          rgb_acc = {rgb_acc[7:0], b};
          field_cnt++;
        end else begin
          ix = entry_cnt[7:0];
          field_cnt = '0;
          entry_cnt = entry_cnt + 9'd1;
          if (entry_cnt >= entry_target) begin
            halted = 1'b1;
            note_result(pngpal_pkg::KIND_ENTRY, ix, {rgb_acc, b}, 9'd0, 1'b0);
            note_result(pngpal_pkg::KIND_DONE, 8'd0, 24'd0, entry_cnt, 1'b1);
          end else begin
            note_result(pngpal_pkg::KIND_ENTRY, ix, {rgb_acc, b}, 9'd0, 1'b1);
          end
          rgb_acc = '0;
        end
      end
      default: halted = 1'b1;
    endcase
  endtask

  task automatic check_result();
    palette_result_t w;
    if (palette_results_q.size() == 0) begin
      report_mismatch($sformatf("result kind %0d with nothing expected", out_tuser));
      return;
    end
    w = palette_results_q.pop_front();
    if (out_tuser !== w.kind)
      report_mismatch($sformatf("kind %0d, expected %0d", out_tuser, w.kind));
    if (out_tdata[7:0] !== w.idx)
      report_mismatch($sformatf("index %0d, expected %0d", out_tdata[7:0], w.idx));
    if (out_tdata[31:8] !== w.color)
      report_mismatch($sformatf("color %06h, expected %06h", out_tdata[31:8], w.color));
    if (out_tdata[40:32] !== w.count)
      report_mismatch($sformatf("count %0d, expected %0d", out_tdata[40:32], w.count));
    if (out_tlast !== w.last)
      report_mismatch($sformatf("last %0d, expected %0d", out_tlast, w.last));
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else if (rst_n) begin
      if (out_tvalid && out_tready) begin
        check_result();
        out_fired = 1'b1;
      end
      if (cfg_we) size_reg = cfg_wdata;
      if (in_tvalid && in_tready) begin
        walk_png_byte(in_tdata, in_tuser);
        in_fired = 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_fired) begin
        in_fired = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (file_bytes_q.size() != 0) begin
          cur = file_bytes_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= cur.data;
          in_tuser <= cur.first;
          in_gap = pick_gap(in_calm);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fired) begin
        out_fired = 1'b0;
        out_gap = pick_gap(out_calm);
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic first);
    build_q.push_back('{b, first});
  endtask

  task automatic queue_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) queue_byte(w[8*i +: 8], 1'b0);
  endtask

  task automatic queue_sig();
    queue_byte(8'($urandom_range(0, 255)), 1'b1);
    repeat (7) queue_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic queue_chunk(input logic [31:0] len, input logic [31:0] tag);
    queue_word(len);
    queue_word(tag);
    repeat (len) queue_byte(8'($urandom_range(0, 255)), 1'b0);
    queue_word($urandom);
  endtask

  task automatic send_file();
    while (build_q.size() != 0) file_bytes_q.push_back(build_q.pop_front());
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (file_bytes_q.size() != 0 || in_tvalid || palette_results_q.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_file_size(input logic [28:0] v);
    wait_idle();
    @(negedge clk);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic build_file(input bit big);
    int nchunks;
    int sel;
    queue_sig();
    nchunks = $urandom_range(1, 4);
    for (int i = 0; i < nchunks; i++) begin
      sel = $urandom_range(0, 9);
      if (big && i == nchunks - 1)
        queue_chunk(32'($urandom_range(768, 800)), PLTE_TAG);
      else if (sel < 5)
        queue_chunk(32'($urandom_range(0, 12)), (sel == 0) ? IHDR_TAG : 32'($urandom));
      else if (sel < 8)
        queue_chunk(32'($urandom_range(0, 30)), PLTE_TAG);
      else
        queue_chunk(32'($urandom_range(0, 2)), IEND_TAG);
    end
  endtask

  initial begin
    int random_bytes;
    int f;
    int d;
    bit big_sent;
    random_bytes = 0;
    big_sent = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    repeat (3) queue_byte(8'($urandom_range(0, 255)), 1'b0);
    send_file();

    set_file_size(29'd0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    send_file();

    set_file_size(29'd19);
    queue_byte(8'hFF, 1'b1);
    send_file();

    set_file_size(29'd20);
    queue_sig();
    queue_word(32'd0);
    queue_word(IEND_TAG);
    send_file();

    set_file_size(29'd31);
    queue_sig();
    queue_chunk(32'd0, IHDR_TAG);
    send_file();

    set_file_size(29'd268435456);
    queue_sig();
    queue_word(32'd3);
    queue_word(PLTE_TAG);
    repeat (3) queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_sig();
    queue_word(32'hFFFF_FFFF);
    send_file();

    set_file_size(29'd40);
    queue_sig();
    queue_word(32'd2);
    queue_word(PLTE_TAG);
    queue_sig();
    queue_word(32'd6);
    queue_word(PLTE_TAG);
    repeat (3) queue_byte(8'h00, 1'b0);
    queue_sig();
    queue_word(32'd0);
    queue_word(IEND_TAG);
    send_file();

    set_file_size(29'd1000);
    queue_sig();
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    send_file();
    set_file_size(29'd100);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'hF4, 1'b0);
    send_file();

    while (random_bytes < RANDOM_BYTES) begin
      build_file(!big_sent);
      big_sent = 1'b1;
      d = $urandom_range(0, 6);
      f = build_q.size() + d - 3;
      if (f < 0) f = 0;
      case ($urandom_range(0, 9))
        0: f = $urandom_range(0, 19);
        1: f = 268435456;
        2: f = $urandom_range(0, 268435456);
        default: ;
      endcase
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, build_q.size() - 1)) void'(build_q.pop_back());
      if ($urandom_range(0, 9) == 0 && build_q.size() > 1)
        build_q[$urandom_range(1, build_q.size() - 1)].first = 1'b1;
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(3, 10)) queue_byte(8'($urandom_range(0, 255)), 1'b0);
      random_bytes += build_q.size();
      set_file_size(29'(f));
      send_file();
      if ($urandom_range(0, 2) == 0) begin
        build_file(1'b0);
        random_bytes += build_q.size();
        send_file();
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== png_palette_chunk_extractor.f =====
src/pngpal_pkg.sv
src/pngpal_parser.sv
src/pngpal_fifo.sv
src/pngpal_emitter.sv
src/png_palette_chunk_extractor.sv
tb/sv/png_palette_chunk_extractor_test.sv
